/* sv/sdes_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// S-DES package
// Shared types, permutation tables, S-boxes and helper functions.
// ----------------------------------------------------------------------------
package sdes_pkg;

   localparam int KEY_W  = 10;
   localparam int BYTE_W = 8;
   localparam int NIB_W  = 4;

   // Permutation tables, position 0 is the MSB.
   localparam int P10_TAB [10] = '{2, 4, 1, 6, 3, 9, 0, 8, 7, 5};
   localparam int P8_TAB  [8]  = '{5, 2, 6, 3, 7, 4, 9, 8};
   localparam int IP_TAB  [8]  = '{1, 5, 2, 0, 3, 7, 4, 6};
   localparam int IPI_TAB [8]  = '{3, 0, 2, 4, 6, 1, 7, 5};
   localparam int EP_TAB  [8]  = '{3, 0, 1, 2, 1, 2, 3, 0};
   localparam int P4_TAB  [4]  = '{1, 3, 2, 0};

   // S-boxes indexed [row][col].
   localparam logic [1:0] SBOX0 [4][4] = '{'{2'd1, 2'd0, 2'd3, 2'd2},
                                           '{2'd3, 2'd2, 2'd1, 2'd0},
                                           '{2'd0, 2'd2, 2'd1, 2'd3},
                                           '{2'd3, 2'd1, 2'd3, 2'd2}};
   localparam logic [1:0] SBOX1 [4][4] = '{'{2'd0, 2'd1, 2'd2, 2'd3},
                                           '{2'd2, 2'd0, 2'd1, 2'd3},
                                           '{2'd3, 2'd0, 2'd1, 2'd0},
                                           '{2'd2, 2'd1, 2'd0, 2'd3}};

   typedef struct packed {
      logic [BYTE_W-1:0] k1;
      logic [BYTE_W-1:0] k2;
   } sdes_subkeys_type;

   typedef struct packed {
      logic s1_valid;
      logic s2_valid;
   } sdes_pipe_stat_type;

   function automatic logic [9:0] perm_p10(input logic [9:0] v);
      logic [9:0] r;
      for (int i = 0; i < 10; i++) r[9-i] = v[9-P10_TAB[i]];
      return r;
   endfunction

   function automatic logic [7:0] perm_p8(input logic [9:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[7-i] = v[9-P8_TAB[i]];
      return r;
   endfunction

   function automatic logic [7:0] perm_ip(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[7-i] = v[7-IP_TAB[i]];
      return r;
   endfunction

   function automatic logic [7:0] perm_ipi(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[7-i] = v[7-IPI_TAB[i]];
      return r;
   endfunction

   function automatic logic [7:0] perm_ep(input logic [3:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[7-i] = v[3-EP_TAB[i]];
      return r;
   endfunction

   function automatic logic [3:0] perm_p4(input logic [3:0] v);
      logic [3:0] r;
      for (int i = 0; i < 4; i++) r[3-i] = v[3-P4_TAB[i]];
      return r;
   endfunction

   // Expansion, subkey mix and S-box lookup; P4 is applied in the next stage.
   function automatic logic [3:0] sbox_mix(input logic [3:0] nib, input logic [7:0] sub);
      logic [7:0] e;
      logic [3:0] a;
      logic [3:0] b;
      e = perm_ep(nib) ^ sub;
      a = e[7:4];
      b = e[3:0];
      return {SBOX0[{a[3], a[0]}][a[2:1]], SBOX1[{b[3], b[0]}][b[2:1]]};
   endfunction

endpackage
`default_nettype wire

/* sv/sdes_key_sched.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// S-DES key schedule
// Holds the key register and derives subkeys K1 and K2.
// ----------------------------------------------------------------------------
module sdes_key_sched (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [9:0]                csr_wr_data,
   output sdes_pkg::sdes_subkeys_type     subkeys
);
   import sdes_pkg::*;

   logic [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0] key_in;
   logic [KEY_W-1:0] kp;
   logic [4:0]       hi;
   logic [4:0]       lo;

   assign key_in = csr_wr_en ? csr_wr_data : key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign kp = perm_p10(key_ff);
   assign hi = kp[9:5];
   assign lo = kp[4:0];

   // rotate left by 1 for K1, by 3 in total for K2
   assign subkeys.k1 = perm_p8({hi[3:0], hi[4], lo[3:0], lo[4]});
   assign subkeys.k2 = perm_p8({hi[1:0], hi[4:2], lo[1:0], lo[4:2]});

endmodule
`default_nettype wire

/* sv/sdes_pipe.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// S-DES data pipeline
// Three register stages: IP and round-1 S-boxes, round-1 P4 and round-2
// S-boxes, round-2 P4 and IP inverse into the output register.
// ----------------------------------------------------------------------------
module sdes_pipe (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  sdes_pkg::sdes_subkeys_type     subkeys,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic                      req_decrypt,
   input  wire logic [7:0]                req_data,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [7:0]                     rsp_data,
   output sdes_pkg::sdes_pipe_stat_type   stat
);
   import sdes_pkg::*;

   // stage 1
   logic             v1_ff, v1_in;
   logic             dec1_ff;
   logic [NIB_W-1:0] left1_ff, right1_ff, s1_ff;
   // stage 2
   logic             v2_ff, v2_in;
   logic [NIB_W-1:0] right2_ff, mid2_ff, s2_ff;
   // stage 3
   logic             v3_ff, v3_in;
   logic [7:0]       res_ff;

   logic             rdy1, rdy2, rdy3;
   logic [7:0]       ip;
   logic [7:0]       first_key, second_key;
   logic [NIB_W-1:0] mid, top;

   assign rdy3 = !v3_ff || rsp_tready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign v1_in = req_tvalid || (v1_ff && !rdy2);
   assign v2_in = v1_ff || (v2_ff && !rdy3);
   assign v3_in = v2_ff || (v3_ff && !rsp_tready);

   assign ip         = perm_ip(req_data);
   assign first_key  = req_decrypt ? subkeys.k2 : subkeys.k1;
   assign second_key = dec1_ff ? subkeys.k1 : subkeys.k2;
   assign mid        = left1_ff ^ perm_p4(s1_ff);
   assign top        = right2_ff ^ perm_p4(s2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= v1_in;
         if (rdy2) v2_ff <= v2_in;
         if (rdy3) v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_tvalid) begin
         dec1_ff   <= req_decrypt;
         left1_ff  <= ip[7:4];
         right1_ff <= ip[3:0];
         s1_ff     <= sbox_mix(ip[3:0], first_key);
      end
      if (rdy2 && v1_ff) begin
         right2_ff <= right1_ff;
         mid2_ff   <= mid;
         s2_ff     <= sbox_mix(mid, second_key);
      end
      if (rdy3 && v2_ff) begin
         res_ff <= perm_ipi({top, mid2_ff});
      end
   end

   assign req_tready    = rdy1;
   assign rsp_tvalid    = v3_ff;
   assign rsp_data      = res_ff;
   assign stat.s1_valid = v1_ff;
   assign stat.s2_valid = v2_ff;

endmodule
`default_nettype wire

/* sv/simplified_des_byte_cipher.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// Simplified DES byte cipher
// Encrypts or decrypts one byte per request with a 10-bit S-DES key.
// ----------------------------------------------------------------------------
// Each request byte passes IP, two Feistel rounds and IP inverse through a
// three-stage pipeline: one byte per clock sustained with rsp_tready high;
// an accepted request moves through stage 1, stage 2 and the output register,
// which drives the rsp side. Every stage holds its own valid bit and a
// per-stage ready, so a stall on rsp_tready only fills the pipe; nothing is
// dropped or repeated. The key is loaded through csr_wr_en / csr_wr_data
// (reset value zero) and must only change while no request is in flight,
// since subkeys are derived from it combinationally.
module simplified_des_byte_cipher (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [9:0]  csr_wr_data,   // cipher_key
   // request side
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,     // [7:0] data_byte
   input  wire logic [0:0]  req_tuser,     // [0] action: 0 encrypt, 1 decrypt
   // result side
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata      // [7:0] result_byte
);
   import sdes_pkg::*;

   sdes_subkeys_type   subkeys;
   sdes_pipe_stat_type stat;

   // key register and subkey derivation
   sdes_key_sched u_key (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .subkeys     (subkeys)
   );

   // data path
   sdes_pipe u_pipe (
      .clock       (clock),
      .reset       (reset),
      .subkeys     (subkeys),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_decrypt (req_tuser[0]),
      .req_data    (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_data    (rsp_tdata),
      .stat        (stat)
   );

   // an accepted request always lands in stage 1
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> stat.s1_valid)
      else $error("accepted request not in stage 1");

   // an empty stage 2 always takes what stage 1 holds
   a_s1_moves: assert property (@(posedge clock) disable iff (reset)
      stat.s1_valid && !stat.s2_valid |=> stat.s2_valid)
      else $error("stage 1 request lost");

   // an empty output register always takes what stage 2 holds
   a_s2_moves: assert property (@(posedge clock) disable iff (reset)
      stat.s2_valid && !rsp_tvalid |=> rsp_tvalid)
      else $error("stage 2 request lost");

   // a stalled result keeps stage 2 occupied
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && stat.s2_valid |=> stat.s2_valid && rsp_tvalid)
      else $error("request dropped during stall");

endmodule
`default_nettype wire

/* bench/tb_simplified_des_byte_cipher.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for simplified_des_byte_cipher
// Streams encrypt and decrypt requests through the S-DES byte cipher under
// several keys and compares every result byte, in order, against an
// independent bit-level model of the cipher kept in a small scoreboard.
// ----------------------------------------------------------------------------

// Permutation tables: one 4-bit source position per output bit, the first
// output bit (MSB) in the highest nibble. Position 0 is the source MSB.
localparam logic [39:0] P10_POS = {4'd2, 4'd4, 4'd1, 4'd6, 4'd3, 4'd9, 4'd0, 4'd8, 4'd7, 4'd5};
localparam logic [31:0] P8_POS  = {4'd5, 4'd2, 4'd6, 4'd3, 4'd7, 4'd4, 4'd9, 4'd8};
localparam logic [31:0] IP_POS  = {4'd1, 4'd5, 4'd2, 4'd0, 4'd3, 4'd7, 4'd4, 4'd6};
localparam logic [31:0] IPI_POS = {4'd3, 4'd0, 4'd2, 4'd4, 4'd6, 4'd1, 4'd7, 4'd5};
localparam logic [31:0] EP_POS  = {4'd3, 4'd0, 4'd1, 4'd2, 4'd1, 4'd2, 4'd3, 4'd0};
localparam logic [15:0] P4_POS  = {4'd1, 4'd3, 4'd2, 4'd0};

// S-boxes, row-major, entry [0][0] in the top two bits.
localparam logic [31:0] S0_BOX = {2'd1, 2'd0, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0,
                                  2'd0, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd3, 2'd2};
localparam logic [31:0] S1_BOX = {2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3,
                                  2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3};

typedef enum logic {
   ACT_ENCRYPT = 1'b0,
   ACT_DECRYPT = 1'b1
} cipher_action_e;

typedef enum int {
   RDY_ALWAYS,
   RDY_COIN,
   RDY_PATTERN,
   RDY_SPARSE
} ready_mode_e;

class cipher_scoreboard;
   logic [7:0] expected_bytes[$];
   logic [9:0] key;
   int         errors;

   function new();
      key    = '0;
      errors = 0;
   endfunction

   static function logic [9:0] permute(logic [9:0] v, int inw, logic [39:0] tab, int outw);
      logic [9:0] r;
      int         p;
      r = '0;
      for (int i = 0; i < outw; i++) begin
         p = int'(tab[4*(outw-1-i) +: 4]);
         r = {r[8:0], v[inw-1-p]};
      end
      return r;
   endfunction

   static function logic [4:0] rotl5(logic [4:0] x, int n);
      logic [9:0] t;
      t = {x, x} << n;
      return t[9:5];
   endfunction

   static function logic [7:0] subkey(logic [9:0] k, int rot);
      logic [9:0] p;
      logic [9:0] s;
      p = permute(k, 10, P10_POS, 10);
      s = permute({rotl5(p[9:5], rot), rotl5(p[4:0], rot)}, 10, {8'h00, P8_POS}, 8);
      return s[7:0];
   endfunction

   static function logic [1:0] sbox(logic [31:0] box, logic [1:0] row, logic [1:0] col);
      int idx;
      idx = row * 4 + col;
      return box[2*(15-idx) +: 2];
   endfunction

   static function logic [3:0] feistel(logic [3:0] nib, logic [7:0] sk);
      logic [9:0] e;
      logic [9:0] p;
      logic [3:0] a;
      logic [3:0] b;
      e = permute({6'd0, nib}, 4, {8'h00, EP_POS}, 8) ^ {2'b00, sk};
      a = e[7:4];
      b = e[3:0];
      p = permute({6'd0, sbox(S0_BOX, {a[3], a[0]}, a[2:1]), sbox(S1_BOX, {b[3], b[0]}, b[2:1])},
                  4, {24'h0, P4_POS}, 4);
      return p[3:0];
   endfunction

   // Whole cipher on one byte: IP, round, swap, round, IP inverse.
   static function logic [7:0] transform(logic [9:0] k, cipher_action_e act, logic [7:0] din);
      logic [7:0] k1;
      logic [7:0] k2;
      logic [7:0] first;
      logic [7:0] second;
      logic [9:0] ip;
      logic [3:0] mid;
      logic [3:0] top;
      logic [9:0] res;
      k1     = subkey(k, 1);
      k2     = subkey(k, 3);
      first  = (act == ACT_DECRYPT) ? k2 : k1;
      second = (act == ACT_DECRYPT) ? k1 : k2;
      ip     = permute({2'b00, din}, 8, {8'h00, IP_POS}, 8);
      mid    = ip[7:4] ^ feistel(ip[3:0], first);
      top    = ip[3:0] ^ feistel(mid, second);
      res    = permute({2'b00, top, mid}, 8, {8'h00, IPI_POS}, 8);
      return res[7:0];
   endfunction

   function void set_key(logic [9:0] k);
      key = k;
   endfunction

   function void note_request(cipher_action_e act, logic [7:0] din);
      expected_bytes.insert(expected_bytes.size(), transform(key, act, din));
   endfunction

   function void check_result(logic [7:0] got);
      logic [7:0] want;
      if (expected_bytes.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %02h", $time, got);
         errors++;
      end else begin
         want = expected_bytes.pop_front();
         if (got !== want) begin
            $display("%0t: result_byte mismatch, expected %02h, actual %02h", $time, want, got);
            errors++;
         end
      end
   endfunction

   function int pending_count();
      return expected_bytes.size();
   endfunction
endclass

module tb_simplified_des_byte_cipher;

   localparam int RANDOM_ITEMS = 650;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 250;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       csr_wr_en   = 1'b0;
   logic [9:0] csr_wr_data = '0;
   logic       req_tvalid  = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata   = '0;   // [7:0] data_byte
   logic [0:0] req_tuser   = '0;   // [0] action: 0 encrypt, 1 decrypt
   logic       rsp_tvalid;
   logic       rsp_tready  = 1'b0;
   logic [7:0] rsp_tdata;          // [7:0] result_byte

   // set by the stimulus, taken and cleared by the receiver process
   bit         hold_off_req = 1'b0;
   int         cycle_count  = 0;
   logic [9:0] key_now      = '0;

   cipher_scoreboard sb = new();

   simplified_des_byte_cipher u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always #4 clock = ~clock;

   // Watchdog: a hung pipe or a lost result ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Monitor. Values seen at the edge are the pre-edge ones, so a handshake
   // here is exactly the one the block takes. Key writes are mirrored into
   // the scoreboard at the edge where the block latches them.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en)
            sb.set_key(csr_wr_data);
         if (req_tvalid && req_tready)
            sb.note_request(cipher_action_e'(req_tuser[0]), req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
      end
   end

   // Receiver: picks its own ready pattern for random stretches; a long
   // hold-off asked by the stimulus is counted out here.
   initial begin : rsp_side
      ready_mode_e mode;
      int          mode_left;
      int          hold_left;
      int          phase;
      mode      = RDY_ALWAYS;
      mode_left = 0;
      hold_left = 0;
      phase     = 0;
      forever begin
         @(posedge clock);
         phase++;
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = ready_mode_e'($urandom_range(0, 3));
            mode_left = $urandom_range(30, 150);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               RDY_ALWAYS:  rsp_tready <= 1'b1;
               RDY_COIN:    rsp_tready <= 1'($urandom_range(0, 1));
               RDY_PATTERN: rsp_tready <= (phase % 5) != 4;   // one stall in five
               default:     rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Offer one request and hold it until the block takes it. Called right
   // after a rising edge; returns on the edge of acceptance.
   task automatic send_request(input cipher_action_e act, input logic [7:0] din);
      req_tvalid   <= 1'b1;
      req_tuser[0] <= act;
      req_tdata    <= din;
      do @(posedge clock); while (!req_tready);
   endtask

   // Sender gap; the data lines carry junk meanwhile.
   task automatic idle_cycles(input int n);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         req_tuser  <= 1'($urandom);
         repeat (n) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every request has come back. The first
   // edge lets the monitor log the last accepted request.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_count() != 0)
         @(posedge clock);
   endtask

   // Key changes only with the pipe empty: subkeys are combinational.
   task automatic write_key(input logic [9:0] k);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= k;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      key_now      = k;
   endtask

   task automatic send_random();
      logic [7:0] x;
      x = 8'($urandom);
      send_request(cipher_action_e'($urandom_range(0, 1)), x);
   endtask

   initial begin : stimulus
      logic [7:0] x;
      int         items_sent;
      int         seg;
      int         seg_len;
      int         burst_left;
      int         gap;
      logic [9:0] k;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // reset key (zero): field extremes and alternating patterns, both ways
      send_request(ACT_ENCRYPT, 8'h00);
      send_request(ACT_DECRYPT, 8'h00);
      send_request(ACT_ENCRYPT, 8'hFF);
      send_request(ACT_DECRYPT, 8'hFF);
      send_request(ACT_ENCRYPT, 8'h55);
      send_request(ACT_DECRYPT, 8'hAA);
      send_request(ACT_ENCRYPT, 8'h80);
      send_request(ACT_DECRYPT, 8'h01);
      drain_results();

      // all-ones key
      write_key(10'h3FF);
      send_request(ACT_ENCRYPT, 8'h00);
      send_request(ACT_DECRYPT, 8'hFF);
      send_request(ACT_ENCRYPT, 8'hA5);
      send_request(ACT_DECRYPT, 8'h5A);
      drain_results();

      // textbook key 1010000010 with its usual plaintext, then back again
      write_key(10'h282);
      send_request(ACT_ENCRYPT, 8'h97);
      send_request(ACT_DECRYPT, 8'h38);
      send_request(ACT_ENCRYPT, 8'h7F);
      send_request(ACT_DECRYPT, 8'hFE);
      drain_results();

      // zero key written explicitly, then a single-bit key
      write_key(10'h000);
      send_request(ACT_ENCRYPT, 8'hFF);
      send_request(ACT_DECRYPT, 8'h00);
      drain_results();
      write_key(10'h200);
      send_request(ACT_ENCRYPT, 8'h0F);
      send_request(ACT_DECRYPT, 8'hF0);
      drain_results();

      // --- random part: segments under one key, bursts with gaps ---
      items_sent = 0;
      seg        = 0;
      burst_left = 0;
      while (items_sent < RANDOM_ITEMS) begin
         drain_results();
         case (seg % 4)
            1:       k = 10'h3FF;
            3:       k = 10'h000;
            default: k = 10'($urandom);
         endcase
         write_key(k);
         seg_len = $urandom_range(40, 120);
         for (int i = 0; i < seg_len; i++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               idle_cycles(gap);
            end
            burst_left--;
            if ($urandom_range(0, 3) == 0) begin
               // round trip: encrypt a byte, then decrypt what it became
               x = 8'($urandom);
               send_request(ACT_ENCRYPT, x);
               send_request(ACT_DECRYPT, sb.transform(key_now, ACT_ENCRYPT, x));
               items_sent += 2;
            end else begin
               send_random();
               items_sent++;
            end
         end
         // long receiver hold-off while requests keep coming, back to back
         if (seg == 2 || seg == 5) begin
            hold_off_req = 1'b1;
            repeat (40) send_random();
            items_sent += 40;
         end
         seg++;
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending_count() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* filelist.f */
sv/sdes_pkg.sv
sv/sdes_key_sched.sv
sv/sdes_pipe.sv
sv/simplified_des_byte_cipher.sv
bench/tb_simplified_des_byte_cipher.sv
